// ===== design/pda_pkg.sv =====
// ----------------------------------------------------------------------------
// pda_pkg: shared types and constants of the Poisson deviance accumulator
// Widths, status codes, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none
package pda_pkg;
	localparam int MAX_FOLDS    = 16;
	localparam int MAX_LEARNERS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int DEPTH        = MAX_FOLDS * MAX_LEARNERS;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int FOLD_IDX_W   = $clog2(MAX_FOLDS);
	localparam int LRN_IDX_W    = $clog2(MAX_LEARNERS);
	localparam int SUM_W        = 47;
	localparam int CNT_W        = $clog2(FRAC_BITS);
	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_FOLD     = 2'd1,
		ST_NEG_EXPOSURE = 2'd2
	} pda_status_t;

	typedef enum logic [0:0] {
		REG_NUM_FOLDS = 1'b0,
		REG_MIN_MEAN  = 1'b1
	} pda_reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_EVAL, S_NORM, S_SQ, S_LNMUL, S_TERM, S_ACC, S_EMIT
	} pda_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_READ, OP_EVAL, OP_NORM, OP_SQUARE, OP_LNMUL,
		OP_TERM, OP_ACC, OP_EMIT
	} pda_op_t;

	typedef struct packed {
		pda_op_t op;
	} pda_cmd_t;

	typedef struct packed {
		logic accepted;
		logic final_eval;
		logic event_req;
		logic norm_done;
		logic out_free;
	} pda_stat_t;
endpackage
`default_nettype wire

// ===== design/pda_if.sv =====
// ----------------------------------------------------------------------------
// pda_in_if / pda_out_if: observation and result channels
// Valid/ready channels carrying one observation item or one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface pda_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] hazard;
	logic signed [31:0] exposure;
	logic               event_req;
	logic [4:0]         fold;
	logic [3:0]         learner;

	modport source(output valid, hazard, exposure, event_req, fold, learner, input ready);
	modport sink(input valid, hazard, exposure, event_req, fold, learner, output ready);
endinterface

interface pda_out_if;
	logic        valid;
	logic        ready;
	logic [46:0] deviance;
	logic        poisoned;
	logic [1:0]  status;

	modport source(output valid, deviance, poisoned, status, input ready);
	modport sink(input valid, deviance, poisoned, status, output ready);
endinterface
`default_nettype wire

// ===== design/poisson_deviance_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// poisson_deviance_accumulator_core: per fold and learner Poisson deviance
// Top level with the APB register port, controller and datapath.
// ----------------------------------------------------------------------------
// One item is in work at a time. An item that ends early (bad fold, negative
// exposure, poisoned or newly poisoned accumulator) goes from evaluation
// straight to the result; a non-event item adds an accumulate step; an event
// item also runs the one-bit-a-cycle normalizer, the 16 serial squarings of
// the log unit, the log multiply and the term step before accumulating. The
// accumulator store needs no clearing pass after reset: each entry has a
// valid bit cleared by reset. Registers: num_folds at 0x0, min_mean at 0x4.
`default_nettype none
module poisson_deviance_accumulator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	pda_in_if.sink           obs,
	pda_out_if.source        res
);
	import pda_pkg::*;

	logic [4:0]  num_folds_q;
	logic [16:0] min_mean_q;
	pda_cmd_t    cmd;
	pda_stat_t   stat;
	pda_reg_t    reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = pda_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_folds_q <= 5'd16;
			min_mean_q  <= 17'd1;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_NUM_FOLDS: num_folds_q <= pwdata[4:0];
				REG_MIN_MEAN:  min_mean_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_NUM_FOLDS: prdata = {27'd0, num_folds_q};
			REG_MIN_MEAN:  prdata = {15'd0, min_mean_q};
			default:       prdata = '0;
		endcase
	end

	pda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	pda_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.num_folds (num_folds_q),
		.min_mean  (min_mean_q),
		.obs       (obs),
		.res       (res)
	);

	// Only one item is in work, so acceptance closes the input side.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(obs.valid && obs.ready) |=> !obs.ready)
		else $error("input accepted while an item is in work");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != ST_OK) |-> (res.deviance == '0 && !res.poisoned))
		else $error("error result carries accumulator data");

	a_poison_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.poisoned) |-> (res.deviance == '0 && res.status == ST_OK))
		else $error("poisoned result carries a sum or an error");
endmodule
`default_nettype wire

// ===== design/pda_ctrl.sv =====
// ----------------------------------------------------------------------------
// pda_ctrl: sequencing state machine
// Steps one item through read, evaluate, log and accumulate phases.
// ----------------------------------------------------------------------------
`default_nettype none
module pda_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pda_pkg::pda_stat_t stat,
	output pda_pkg::pda_cmd_t      cmd
);
	import pda_pkg::*;

	pda_state_t       state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_SQ) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.op = OP_LOAD;
				if (stat.accepted) state_nx = S_READ;
			end
			S_READ: begin
				cmd.op   = OP_READ;
				state_nx = S_EVAL;
			end
			S_EVAL: begin
				cmd.op = OP_EVAL;
				priority if (stat.final_eval) state_nx = S_EMIT;
				else if (stat.event_req) state_nx = S_NORM;
				else state_nx = S_ACC;
			end
			S_NORM: begin
				cmd.op = OP_NORM;
				if (stat.norm_done) state_nx = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQUARE;
				if (cnt_q == CNT_W'(FRAC_BITS - 1)) state_nx = S_LNMUL;
			end
			S_LNMUL: begin
				cmd.op   = OP_LNMUL;
				state_nx = S_TERM;
			end
			S_TERM: begin
				cmd.op   = OP_TERM;
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.op   = OP_ACC;
				state_nx = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.op   = OP_EMIT;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/pda_datapath.sv =====
// ----------------------------------------------------------------------------
// pda_datapath: accumulator store, mean, natural log and saturating sum
// Executes the commands of the controller and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module pda_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pda_pkg::pda_cmd_t cmd,
	output pda_pkg::pda_stat_t    stat,
	input  wire logic [4:0]       num_folds,
	input  wire logic [16:0]      min_mean,
	pda_in_if.sink                obs,
	pda_out_if.source             res
);
	import pda_pkg::*;

	// Entry layout: poison flag above the sum.
	logic [SUM_W:0]   mem [DEPTH];
	logic             vld_q [DEPTH];

	logic [31:0]      haz_q, exp_q;
	logic             evt_q;
	logic [4:0]       fold_q;
	logic [3:0]       lrn_q;
	logic [SUM_W:0]   rd_q;
	logic             rdv_q;
	logic [63:0]      prod_q;
	logic [31:0]      mu_q, x_q;
	logic [4:0]       k_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [52:0]      lnp_q;
	logic             lneg_q;
	logic [32:0]      term_q;
	logic [SUM_W-1:0] res_dev_q, out_dev_q;
	logic             res_poi_q, out_poi_q;
	pda_status_t      res_st_q, out_st_q;
	logic             out_vld_q;

	logic [4:0]       fold_m1, limit;
	logic [IDX_W-1:0] idx;
	logic             fold_ok, old_poison, final_c;
	logic [SUM_W-1:0] old_sum;
	logic [16:0]      floor_v;
	logic [31:0]      mu_c;
	logic [63:0]      sq;
	logic [32:0]      sq_t;
	logic [4:0]       ipm;
	logic [20:0]      mag;
	logic [53:0]      lnr;
	logic signed [23:0] ln_s;
	logic signed [35:0] c_s;
	logic [SUM_W:0]   sum_w;
	logic [SUM_W-1:0] sum_sat;
	logic             wr_en;
	logic [SUM_W:0]   wr_data;

	assign obs.ready = (cmd.op == OP_LOAD);

	assign fold_m1    = fold_q - 5'd1;
	assign idx        = {fold_m1[FOLD_IDX_W-1:0], lrn_q[LRN_IDX_W-1:0]};
	assign limit      = (num_folds < 5'(MAX_FOLDS)) ? num_folds : 5'(MAX_FOLDS);
	assign fold_ok    = (fold_q != 5'd0) && (fold_q <= limit);
	assign old_poison = rdv_q & rd_q[SUM_W];
	assign old_sum    = rdv_q ? rd_q[SUM_W-1:0] : '0;
	assign final_c    = !fold_ok || exp_q[31] || old_poison || haz_q[31];
	assign floor_v    = (min_mean == 17'd0) ? 17'd1 : min_mean;
	assign mu_c       = ((prod_q[63:48] != 16'd0) || (prod_q[47:16] < {15'd0, floor_v}))
	                    ? {15'd0, floor_v} : prod_q[47:16];

	// One squaring step of the log2 fraction search on a Q1.31 mantissa.
	assign sq   = 64'(x_q) * 64'(x_q);
	assign sq_t = sq[63:31];

	always_comb begin
		ipm = 5'd0;
		if (k_q < 5'd16) begin
			ipm = 5'd16 - k_q;
			mag = {ipm, 16'd0} - {5'd0, frac_q};
		end else begin
			ipm = k_q - 5'd16;
			mag = {ipm, frac_q};
		end
	end

	assign lnr   = {1'b0, lnp_q} + 54'(64'h8000_0000);
	assign ln_s  = lneg_q ? -$signed({2'b00, lnr[53:32]}) : $signed({2'b00, lnr[53:32]});
	assign c_s   = $signed({4'd0, mu_q}) - 36'(ln_s) - 36'sd65536;
	assign sum_w = {1'b0, old_sum} + {14'd0, term_q, 1'b0};
	assign sum_sat = sum_w[SUM_W] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		if (cmd.op == OP_EVAL && fold_ok && !exp_q[31] && !old_poison && haz_q[31]) begin
			wr_en   = 1'b1;
			wr_data = {1'b1, {SUM_W{1'b0}}};
		end else if (cmd.op == OP_ACC) begin
			wr_en   = 1'b1;
			wr_data = {1'b0, sum_sat};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[idx] <= wr_data;
		if (cmd.op == OP_READ) rd_q <= mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
			rdv_q <= 1'b0;
		end else begin
			if (wr_en) vld_q[idx] <= 1'b1;
			if (cmd.op == OP_READ) rdv_q <= vld_q[idx];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				haz_q  <= obs.hazard;
				exp_q  <= obs.exposure;
				evt_q  <= obs.event_req;
				fold_q <= obs.fold;
				lrn_q  <= obs.learner;
			end
			OP_READ: prod_q <= 64'(haz_q) * 64'(exp_q);
			OP_EVAL: begin
				mu_q   <= mu_c;
				x_q    <= mu_c;
				k_q    <= 5'd31;
				term_q <= {1'b0, mu_c};
				res_dev_q <= '0;
				res_poi_q <= fold_ok && !exp_q[31];
				priority if (!fold_ok) res_st_q <= ST_BAD_FOLD;
				else if (exp_q[31]) res_st_q <= ST_NEG_EXPOSURE;
				else res_st_q <= ST_OK;
			end
			OP_NORM: begin
				if (!x_q[31]) begin
					x_q <= {x_q[30:0], 1'b0};
					k_q <= k_q - 5'd1;
				end
			end
			OP_SQUARE: begin
				x_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
				frac_q <= {frac_q[FRAC_BITS-2:0], sq_t[32]};
			end
			OP_LNMUL: begin
				lnp_q  <= 53'(mag) * 53'(LN2_Q32);
				lneg_q <= (k_q < 5'd16);
			end
			OP_TERM: term_q <= c_s[35] ? 33'd0 : c_s[32:0];
			OP_ACC: begin
				res_dev_q <= sum_sat;
				res_poi_q <= 1'b0;
				res_st_q  <= ST_OK;
			end
			OP_EMIT: begin
				out_dev_q <= res_dev_q;
				out_poi_q <= res_poi_q;
				out_st_q  <= res_st_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign res.valid    = out_vld_q;
	assign res.deviance = out_dev_q;
	assign res.poisoned = out_poi_q;
	assign res.status   = out_st_q;

	assign stat.accepted   = obs.valid && obs.ready;
	assign stat.final_eval = final_c;
	assign stat.event_req  = evt_q;
	assign stat.norm_done  = x_q[31];
	assign stat.out_free   = !out_vld_q || res.ready;
endmodule
`default_nettype wire

// ===== tb/tb_poisson_deviance_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// tb_poisson_deviance_accumulator_core: self-checking testbench
// Drives observation items with random gaps, predicts each result with a
// behavioral model of the deviance accumulators and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_poisson_deviance_accumulator_core;
	import pda_pkg::*;

	localparam logic [46:0] SUM_LIMIT = 47'h7FFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [46:0] deviance;
		logic        poisoned;
		pda_status_t status;
	} dev_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pda_in_if obs ();
	pda_out_if res ();

	poisson_deviance_accumulator_core u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.obs(obs.sink), .res(res.source)
	);

	// Predictor state
	logic [46:0] acc_sum [DEPTH];
	logic        acc_poison [DEPTH];
	logic [4:0]  cur_num_folds;
	logic [16:0] cur_min_mean;

	dev_result_t expected_q[$];
	int fail_count;
	int idle_cycles;
	int stall_long;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ln of a Q16.16 mean, following the log2-by-squaring scheme
	function automatic longint signed ln_fixed(input logic [31:0] mu);
		int k;
		logic [63:0] x;
		logic [63:0] frac;
		longint signed ip;
		logic [63:0] mag;
		logic [63:0] r;
		k = 31;
		while (k > 0 && mu[k] == 1'b0)
			k--;
		x = 64'(mu) << (31 - k);
		frac = 0;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			x = (x * x) >> 31;
			if (x >= 64'h1_0000_0000) begin
				x = x >> 1;
				frac = frac | (64'd1 << (FRAC_BITS - i));
			end
		end
		ip = longint'(k) - FRAC_BITS;
		if (ip >= 0)
			mag = (64'(ip) << FRAC_BITS) + frac;
		else
			mag = (64'(-ip) << FRAC_BITS) - frac;
		r = (mag * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
		return (ip < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic dev_result_t predict_deviance(input logic [31:0] hazard,
			input logic [31:0] exposure, input logic event_req, input logic [4:0] fold,
			input logic [3:0] learner);
		dev_result_t r;
		int limit;
		int idx;
		logic [63:0] floor_v;
		logic [63:0] prod;
		logic [63:0] mu;
		logic [63:0] term;
		logic [63:0] sum;
		longint signed c;
		r = '{deviance: '0, poisoned: 1'b0, status: ST_OK};
		limit = (cur_num_folds < MAX_FOLDS) ? cur_num_folds : MAX_FOLDS;
		if (fold < 1 || fold > limit) begin
			r.status = ST_BAD_FOLD;
			return r;
		end
		if (exposure[31]) begin
			r.status = ST_NEG_EXPOSURE;
			return r;
		end
		idx = (fold - 1) * MAX_LEARNERS + (learner % MAX_LEARNERS);
		if (acc_poison[idx]) begin
			r.poisoned = 1'b1;
			return r;
		end
		if (hazard[31]) begin
			acc_poison[idx] = 1'b1;
			acc_sum[idx] = '0;
			r.poisoned = 1'b1;
			return r;
		end
		floor_v = (cur_min_mean == 0) ? 64'd1 : 64'(cur_min_mean);
		prod = (64'(hazard) * 64'(exposure)) >> FRAC_BITS;
		mu = prod;
		if (prod > 64'hFFFF_FFFF || prod < floor_v)
			mu = floor_v;
		if (event_req) begin
			c = longint'(mu) - ln_fixed(mu[31:0]) - (longint'(1) << FRAC_BITS);
			term = (c < 0) ? 64'd0 : 64'(c);
		end else begin
			term = mu;
		end
		sum = 64'(acc_sum[idx]) + 2 * term;
		if (sum > 64'(SUM_LIMIT))
			sum = 64'(SUM_LIMIT);
		acc_sum[idx] = sum[46:0];
		r.deviance = sum[46:0];
		return r;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	task automatic send_observation(input logic [31:0] hazard, input logic [31:0] exposure,
			input logic event_req, input logic [4:0] fold, input logic [3:0] learner,
			input bit with_gaps);
		int gap;
		gap = with_gaps ? rand_gap() : 0;
		repeat (gap) @(posedge clk);
		obs.valid <= 1'b1;
		obs.hazard <= hazard;
		obs.exposure <= exposure;
		obs.event_req <= event_req;
		obs.fold <= fold;
		obs.learner <= learner;
		@(posedge clk);
		while (!obs.ready)
			@(posedge clk);
		expected_q.push_back(predict_deviance(hazard, exposure, event_req, fold, learner));
		obs.valid <= 1'b0;
		// The block takes no new item until the accepted one is done, so this edge costs no throughput.
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input pda_reg_t index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * int'(index));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_NUM_FOLDS)
			cur_num_folds = value[4:0];
		else
			cur_min_mean = value[16:0];
		@(posedge clk);
	endtask

	// Result checker with random backpressure on the result channel
	always @(posedge clk) begin
		dev_result_t exp_r;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item deviance=%0h", res.deviance);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (res.deviance !== exp_r.deviance) begin
						$error("deviance: expected %0h actual %0h", exp_r.deviance,
							res.deviance);
						fail_count++;
					end
					if (res.poisoned !== exp_r.poisoned) begin
						$error("poisoned: expected %0b actual %0b", exp_r.poisoned,
							res.poisoned);
						fail_count++;
					end
					if (res.status !== exp_r.status) begin
						$error("status: expected %0d actual %0d", exp_r.status, res.status);
						fail_count++;
					end
				end
			end
			if (stall_long > 0) begin
				stall_long <= stall_long - 1;
				res.ready <= 1'b0;
			end else if ($urandom_range(0, 99) == 0) begin
				stall_long <= $urandom_range(10, 40);
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Watchdog: counts cycles in which no item moves on either channel
	always @(posedge clk) begin
		if ((obs.valid && obs.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_directed();
		// Extremes, every status, event and non-event, floor and overflow of the mean
		send_observation(32'h0001_0000, 32'h0001_0000, 1'b0, 5'd1, 4'd0, 1'b0);
		send_observation(32'h0001_0000, 32'h0001_0000, 1'b1, 5'd1, 4'd0, 1'b0);
		send_observation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd16, 4'd15, 1'b0);
		send_observation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 5'd16, 4'd14, 1'b0);
		send_observation(32'h0000_0000, 32'h0000_0000, 1'b1, 5'd2, 4'd3, 1'b0);
		send_observation(32'h0000_0001, 32'h0000_0001, 1'b0, 5'd2, 4'd3, 1'b0);
		send_observation(32'h0001_0000, 32'h0001_0000, 1'b0, 5'd0, 4'd0, 1'b0);
		send_observation(32'h0001_0000, 32'h0001_0000, 1'b0, 5'd17, 4'd0, 1'b0);
		send_observation(32'h0001_0000, 32'h0001_0000, 1'b0, 5'd31, 4'd0, 1'b0);
		send_observation(32'h0001_0000, 32'h8000_0000, 1'b0, 5'd3, 4'd0, 1'b0);
		send_observation(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd0, 4'd0, 1'b0);
		send_observation(32'h8000_0000, 32'h0001_0000, 1'b0, 5'd4, 4'd5, 1'b0);
		send_observation(32'h0001_0000, 32'h0001_0000, 1'b1, 5'd4, 4'd5, 1'b0);
		send_observation(32'h0000_8000, 32'h0000_4000, 1'b1, 5'd5, 4'd6, 1'b0);
		send_observation(32'h0100_0000, 32'h0100_0000, 1'b1, 5'd5, 4'd7, 1'b0);
		send_observation(32'h1234_5678, 32'h0002_0000, 1'b1, 5'd6, 4'd8, 1'b0);
		// Accumulate repeatedly on one accumulator with a mean that overflows and clamps to the floor
		repeat (6)
			send_observation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd7, 4'd9, 1'b0);
		wait_drained();
	endtask

	task automatic test_random(input int count);
		logic [31:0] hazard;
		logic [31:0] exposure;
		logic [4:0] fold;
		int limit;
		for (int i = 0; i < count; i++) begin
			limit = (cur_num_folds == 0) ? 1 : ((cur_num_folds < 16) ? cur_num_folds : 16);
			case ($urandom_range(0, 3))
				0: hazard = $urandom;
				1: hazard = $urandom_range(0, 32'h0004_0000);
				default: hazard = $urandom_range(0, 32'h7FFF_FFFF);
			endcase
			// Keep poisoning rare so most accumulators stay live
			if (hazard[31] && $urandom_range(0, 9) != 0)
				hazard[31] = 1'b0;
			case ($urandom_range(0, 3))
				0: exposure = $urandom;
				1: exposure = $urandom_range(0, 32'h0004_0000);
				default: exposure = $urandom_range(0, 32'h7FFF_FFFF);
			endcase
			if (exposure[31] && $urandom_range(0, 4) != 0)
				exposure[31] = 1'b0;
			if ($urandom_range(0, 9) == 0)
				fold = 5'($urandom);
			else
				fold = 5'($urandom_range(1, limit));
			send_observation(hazard, exposure, 1'($urandom), fold, 4'($urandom), 1'b1);
		end
	endtask

	task automatic test_config_sweep();
		write_register(REG_NUM_FOLDS, 32'd1);
		write_register(REG_MIN_MEAN, 32'd65536);
		test_random(150);
		wait_drained();
		write_register(REG_NUM_FOLDS, 32'd0);
		write_register(REG_MIN_MEAN, 32'd0);
		test_random(40);
		wait_drained();
		write_register(REG_NUM_FOLDS, 32'd31);
		write_register(REG_MIN_MEAN, 32'h1FFFF);
		test_random(200);
		wait_drained();
		write_register(REG_NUM_FOLDS, 32'd8);
		write_register(REG_MIN_MEAN, 32'd300);
		test_random(200);
		wait_drained();
		write_register(REG_NUM_FOLDS, 32'd16);
		write_register(REG_MIN_MEAN, 32'd1);
		test_random(200);
	endtask

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		stall_long = 0;
		cur_num_folds = 5'd16;
		cur_min_mean = 17'd1;
		for (int i = 0; i < DEPTH; i++) begin
			acc_sum[i] = '0;
			acc_poison[i] = 1'b0;
		end
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		obs.valid = 1'b0;
		obs.hazard = '0;
		obs.exposure = '0;
		obs.event_req = 1'b0;
		obs.fold = '0;
		obs.learner = '0;
		res.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		wait_drained();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/pda_pkg.sv
design/pda_if.sv
design/pda_ctrl.sv
design/pda_datapath.sv
design/poisson_deviance_accumulator_core.sv
tb/tb_poisson_deviance_accumulator_core.sv
